FILE: hw/rtl/hue_palette_remap_macros.svh
// Assertion macros for the hue palette remap block.
// Used by the top level only; no other dependencies.
`ifndef HUE_PALETTE_REMAP_MACROS_SVH
`define HUE_PALETTE_REMAP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on i_clk, quiet during reset
`define HPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, clocked on i_clk, quiet during reset
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HPR_ASSERT_NOW(lbl, ante, cons, msg)
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/hpr_pkg.sv
// Shared types, constants and helper functions of the hue palette remap block.
// No dependencies; imported by every module of the block.
package hpr_pkg;

    // palette modes
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_DUO  = 2'd1;
    localparam logic [1:0] MODE_TRIO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_ONE   = 2'd1;
    localparam logic [1:0] REG_TWO   = 2'd2;
    localparam logic [1:0] REG_THREE = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PIX_W      = 24;
    localparam int CH_NUM     = 3;

    // hue sector constants
    localparam int          HUE_SEG    = 43;
    localparam logic [7:0] HUE_BASE_G = 8'd85;
    localparam logic [7:0] HUE_BASE_B = 8'd171;

    // hue divider: 6 quotient bits, 2 per stage
    localparam int NUM_W       = 14;
    localparam int QUO_W       = 6;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = QUO_W / DIV_BITS;
    localparam int MIX_STAGES  = 4;
    localparam int PIPE_STAGES = 1 + DIV_STAGES + MIX_STAGES + 1;

    // gain = mx*1000/255 as mx*GAIN_MUL >> GAIN_SHIFT (exact for mx < 256)
    localparam int           GAIN_PROD_W = 36;
    localparam logic [28:0] GAIN_MUL    = 29'd263173000;
    localparam int           GAIN_SHIFT  = 26;
    localparam int           GAIN_W      = 10;

    // x/1000 as x*DIV1K_MUL >> DIV1K_SHIFT (exact for x <= 255000)
    localparam int           SCALE_W     = 18;
    localparam int           QP_W        = 36;
    localparam logic [18:0] DIV1K_MUL   = 19'd268436;
    localparam int           DIV1K_SHIFT = 28;

    typedef logic [7:0] t_byte;

    // pixel and bypass flag that ride along the pipeline
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             pass;
    } t_side;

    // front stage result
    typedef struct packed {
        t_side            side;
        t_byte            mx;
        t_byte            d;
        logic [NUM_W-1:0] num;
        logic             neg;
        logic             zero_d;
        t_byte            base;
    } t_front;

    // hue divider result
    typedef struct packed {
        t_side             side;
        logic [QUO_W-1:0]  q;
        logic              neg;
        logic              zero_d;
        t_byte             base;
        logic [GAIN_W-1:0] gain;
    } t_div;

    // mix result: per-channel scaled products, channel 0 is red
    typedef struct packed {
        t_side                   side;
        logic [CH_NUM-1:0][QP_W-1:0] qp;
    } t_mix;

    // floor(x/255) for x < 65280
    function automatic t_byte div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

FILE: hw/rtl/hpr_front.sv
// Front stage: max/min, hue sector, dividend magnitude and bypass flag.
// Depends on hpr_pkg.
module hpr_front (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [23:0]          i_pix,
    input  logic [1:0]           i_mode,
    output hpr_pkg::t_front      o_front
);
    import hpr_pkg::*;

    t_byte      w_r, w_g, w_b, w_mx, w_mn, w_mag;
    logic [8:0] w_diff;
    t_byte      w_base;
    t_front     n_front;
    t_front     r_front;

    assign w_r = i_pix[7:0];
    assign w_g = i_pix[15:8];
    assign w_b = i_pix[23:16];

    // brightness and spread
    assign w_mx = (w_r > w_g) ? ((w_r > w_b) ? w_r : w_b) : ((w_g > w_b) ? w_g : w_b);
    assign w_mn = (w_r < w_g) ? ((w_r < w_b) ? w_r : w_b) : ((w_g < w_b) ? w_g : w_b);

    // sector pick, ties go to red then green
    always_comb begin
        if (w_mx == w_r) begin
            w_diff = {1'b0, w_g} - {1'b0, w_b};
            w_base = 8'd0;
        end else if (w_mx == w_g) begin
            w_diff = {1'b0, w_b} - {1'b0, w_r};
            w_base = HUE_BASE_G;
        end else begin
            w_diff = {1'b0, w_r} - {1'b0, w_g};
            w_base = HUE_BASE_B;
        end
    end

    assign w_mag = w_diff[8] ? 8'(-w_diff) : w_diff[7:0];

    always_comb begin
        n_front.side.pix  = i_pix;
        n_front.side.pass = (i_mode == MODE_PASS) || (w_mx == 8'd0);
        n_front.mx        = w_mx;
        n_front.d         = w_mx - w_mn;
        n_front.num       = NUM_W'(w_mag) * NUM_W'(HUE_SEG);
        n_front.neg       = w_diff[8];
        n_front.zero_d    = (w_mx == w_mn);
        n_front.base      = w_base;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

FILE: hw/rtl/hpr_hue_div.sv
// Hue divider: restoring division, two quotient bits per stage, plus gain.
// Depends on hpr_pkg.
module hpr_hue_div (
    input  logic                            i_clk,
    input  logic [hpr_pkg::DIV_STAGES-1:0]  i_en,
    input  hpr_pkg::t_front                 i_front,
    output hpr_pkg::t_div                   o_div
);
    import hpr_pkg::*;

    typedef struct packed {
        t_side side;
        logic  neg;
        logic  zero_d;
        t_byte base;
    } t_hctx;

    logic [NUM_W-1:0] w_rem_in [DIV_STAGES];
    logic [QUO_W-1:0] w_q_in   [DIV_STAGES];
    t_byte            w_d_in   [DIV_STAGES];
    t_hctx            w_ctx_in [DIV_STAGES];
    logic [NUM_W-1:0] n_rem    [DIV_STAGES];
    logic [QUO_W-1:0] n_q      [DIV_STAGES];
    logic [NUM_W-1:0] r_rem    [DIV_STAGES];
    logic [QUO_W-1:0] r_q      [DIV_STAGES];
    t_byte            r_d      [DIV_STAGES];
    t_hctx            r_ctx    [DIV_STAGES];

    logic [GAIN_PROD_W-1:0] r_gprod;
    logic [GAIN_W-1:0]      r_gain;
    logic [GAIN_W-1:0]      r_gain_d;

    // stage inputs: first from the front, then from the previous stage
    always_comb begin
        w_rem_in[0]        = i_front.num;
        w_q_in[0]          = '0;
        w_d_in[0]          = i_front.d;
        w_ctx_in[0].side   = i_front.side;
        w_ctx_in[0].neg    = i_front.neg;
        w_ctx_in[0].zero_d = i_front.zero_d;
        w_ctx_in[0].base   = i_front.base;
        for (int s = 1; s < DIV_STAGES; s++) begin
            w_rem_in[s] = r_rem[s-1];
            w_q_in[s]   = r_q[s-1];
            w_d_in[s]   = r_d[s-1];
            w_ctx_in[s] = r_ctx[s-1];
        end
    end

    // quotient bits, most significant first
    generate
        for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
            localparam int BIT_HI = QUO_W - 1 - s * DIV_BITS;

            always_comb begin
                logic [NUM_W-1:0] rem;
                logic [QUO_W-1:0] q;
                logic [NUM_W-1:0] dsh;
                rem = w_rem_in[s];
                q   = w_q_in[s];
                for (int j = 0; j < DIV_BITS; j++) begin
                    dsh = NUM_W'(w_d_in[s]) << (BIT_HI - j);
                    if (rem >= dsh) begin
                        rem = rem - dsh;
                        q[BIT_HI - j] = 1'b1;
                    end
                end
                n_rem[s] = rem;
                n_q[s]   = q;
            end

            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_rem[s] <= n_rem[s];
                    r_q[s]   <= n_q[s];
                    r_d[s]   <= w_d_in[s];
                    r_ctx[s] <= w_ctx_in[s];
                end
            end
        end
    endgenerate

    // brightness gain: multiply, then take the high bits, then hold
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_gprod <= GAIN_PROD_W'(i_front.mx) * GAIN_PROD_W'(GAIN_MUL);
        end
        if (i_en[1]) begin
            r_gain <= r_gprod[GAIN_SHIFT +: GAIN_W];
        end
        if (i_en[2]) begin
            r_gain_d <= r_gain;
        end
    end

    always_comb begin
        o_div.side   = r_ctx[DIV_STAGES-1].side;
        o_div.q      = r_q[DIV_STAGES-1];
        o_div.neg    = r_ctx[DIV_STAGES-1].neg;
        o_div.zero_d = r_ctx[DIV_STAGES-1].zero_d;
        o_div.base   = r_ctx[DIV_STAGES-1].base;
        o_div.gain   = r_gain_d;
    end

endmodule

FILE: hw/rtl/hpr_mix.sv
// Palette mix: hue, color pair pick, blend, /255, brightness scale.
// Depends on hpr_pkg.
module hpr_mix (
    input  logic                            i_clk,
    input  logic [hpr_pkg::MIX_STAGES-1:0]  i_en,
    input  hpr_pkg::t_div                   i_div,
    input  logic [1:0]                      i_mode,
    input  logic [23:0]                     i_color_one,
    input  logic [23:0]                     i_color_two,
    input  logic [23:0]                     i_color_three,
    output hpr_pkg::t_mix                   o_mix
);
    import hpr_pkg::*;

    t_byte       w_hue, w_qx, w_t;
    logic [23:0] w_ca, w_cb;

    t_byte       r_t;
    logic [23:0] r_ca, r_cb;
    t_side       r_side_a, r_side_b, r_side_c, r_side_d;
    logic [GAIN_W-1:0] r_gain_a, r_gain_b;

    logic [15:0]        n_sum [CH_NUM];
    logic [15:0]        r_sum [CH_NUM];
    logic [SCALE_W-1:0] n_mp  [CH_NUM];
    logic [SCALE_W-1:0] r_mp  [CH_NUM];
    logic [QP_W-1:0]    r_qp  [CH_NUM];

    // signed quotient onto the sector base, wraps mod 256
    assign w_qx  = {2'b00, i_div.q};
    assign w_hue = i_div.zero_d ? 8'd0 :
                   (i_div.neg ? (i_div.base - w_qx) : (i_div.base + w_qx));

    // blend weight and color pair
    always_comb begin
        w_t  = {w_hue[6:0], 1'b0};
        w_ca = '0;
        w_cb = '0;
        case (i_mode)
            MODE_DUO: begin
                w_t  = w_hue;
                w_ca = i_color_one;
                w_cb = i_color_two;
            end
            MODE_TRIO: begin
                w_ca = w_hue[7] ? i_color_two : i_color_one;
                w_cb = w_hue[7] ? i_color_three : i_color_two;
            end
            default: begin
                w_ca = '0;
                w_cb = '0;
            end
        endcase
    end

    // weighted sums per channel
    always_comb begin
        for (int ch = 0; ch < CH_NUM; ch++) begin
            n_sum[ch] = 16'(r_ca[23 - 8*ch -: 8]) * 16'(8'd255 - r_t)
                      + 16'(r_cb[23 - 8*ch -: 8]) * 16'(r_t);
        end
    end

    // mapped color times gain
    always_comb begin
        for (int ch = 0; ch < CH_NUM; ch++) begin
            n_mp[ch] = SCALE_W'(div255(r_sum[ch])) * SCALE_W'(r_gain_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t      <= w_t;
            r_ca     <= w_ca;
            r_cb     <= w_cb;
            r_side_a <= i_div.side;
            r_gain_a <= i_div.gain;
        end
        if (i_en[1]) begin
            r_sum    <= n_sum;
            r_side_b <= r_side_a;
            r_gain_b <= r_gain_a;
        end
        if (i_en[2]) begin
            r_mp     <= n_mp;
            r_side_c <= r_side_b;
        end
        // divide by 1000 through reciprocal product
        if (i_en[3]) begin
            for (int ch = 0; ch < CH_NUM; ch++) begin
                r_qp[ch] <= QP_W'(r_mp[ch]) * QP_W'(DIV1K_MUL);
            end
            r_side_d <= r_side_c;
        end
    end

    always_comb begin
        o_mix.side = r_side_d;
        for (int ch = 0; ch < CH_NUM; ch++) begin
            o_mix.qp[ch] = r_qp[ch];
        end
    end

endmodule

FILE: hw/rtl/hue_palette_remap.sv
// Hue palette remap: takes one RGB pixel per beat, derives an 8-bit hue,
// maps it onto a two- or three-color gradient and scales the result by the
// pixel's brightness (its largest channel). Pass-through mode and black
// pixels come out unchanged; mode code 3 gives black. The block is
// a 9-stage pipeline and takes one pixel every cycle while the output is
// not stalled; the hue division is spread over three of those stages, two
// quotient bits each. Each stage holds its own valid bit and only stalls
// when the stage after it is full and stalled, so bubbles close up while
// the output waits. Configuration writes are registered; they are to be made
// only while no pixel is in flight, which the block does not enforce itself.
// Depends on hpr_pkg, hpr_front, hpr_hue_div, hpr_mix and the macro header.
`include "hue_palette_remap_macros.svh"

module hue_palette_remap (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side; tdata: in_red [7:0], in_green [15:8], in_blue [23:16]
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [23:0]                      i_s_axis_tdata,
    // master side; tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [23:0]                      o_m_axis_tdata,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [hpr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hpr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hpr_pkg::*;

    localparam int OUT_STG = PIPE_STAGES - 1;

    logic [1:0]  r_mode;
    logic [23:0] r_color_one, r_color_two, r_color_three;

    logic [PIPE_STAGES-1:0] r_vld, n_vld, w_en;
    t_front      w_front;
    t_div        w_div;
    t_mix        w_mix;
    logic [23:0] r_out, n_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_PASS;
            r_color_one   <= '0;
            r_color_two   <= '0;
            r_color_three <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:  r_mode        <= i_cfg_data[1:0];
                REG_ONE:   r_color_one   <= i_cfg_data;
                REG_TWO:   r_color_two   <= i_cfg_data;
                REG_THREE: r_color_three <= i_cfg_data;
                default:   r_mode        <= r_mode;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one loads
    always_comb begin
        w_en[OUT_STG] = !r_vld[OUT_STG] || i_m_axis_tready;
        for (int k = OUT_STG - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_s_axis_tvalid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = w_en[0];

    hpr_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_pix   (i_s_axis_tdata),
        .i_mode  (r_mode),
        .o_front (w_front)
    );

    hpr_hue_div u_div (
        .i_clk   (i_clk),
        .i_en    (w_en[DIV_STAGES:1]),
        .i_front (w_front),
        .o_div   (w_div)
    );

    hpr_mix u_mix (
        .i_clk         (i_clk),
        .i_en          (w_en[DIV_STAGES+MIX_STAGES:DIV_STAGES+1]),
        .i_div         (w_div),
        .i_mode        (r_mode),
        .i_color_one   (r_color_one),
        .i_color_two   (r_color_two),
        .i_color_three (r_color_three),
        .o_mix         (w_mix)
    );

    // output register: bypass pixel or scaled color
    always_comb begin
        n_out = w_mix.side.pix;
        if (!w_mix.side.pass) begin
            for (int ch = 0; ch < CH_NUM; ch++) begin
                n_out[8*ch +: 8] = w_mix.qp[ch][DIV1K_SHIFT +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[OUT_STG]) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_vld[OUT_STG];
    assign o_m_axis_tdata  = r_out;

    // input only backs up when the whole pipe is full and the output stalls
    `HPR_ASSERT_NOW(a_stall_full, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready, "input stalled while pipeline has room")
    // an accepted beat occupies the first stage next cycle
    `HPR_ASSERT_NEXT(a_accept_lands, i_s_axis_tvalid && o_s_axis_tready, r_vld[0], "accepted beat lost at first stage")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for hue_palette_remap: random and directed pixels
// with random idling on both streams, checked by an in-bench palette predictor.
// Depends on hpr_pkg and the hue_palette_remap RTL.

module testbench;

    // hue and scaling constants of the remap
    localparam int HUE_SECTOR  = 43;
    localparam int HUE_GREEN   = 85;
    localparam int HUE_BLUE    = 171;
    localparam int HUE_WRAP    = 256;
    localparam int HUE_HALF    = 128;
    localparam int FULL_SCALE  = 255;
    localparam int GAIN_SCALE  = 1000;

    // mode code that the block does not define; maps to black
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int PIPE_DEPTH  = 9;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 40;

    // red in the low byte, as on tdata
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct {
        t_pixel src;
        t_pixel want;
    } t_remap;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        src_valid  = 1'b0;
    logic        src_ready;
    logic [23:0] src_data   = '0;
    logic        sink_valid;
    logic        sink_ready = 1'b0;
    logic [23:0] sink_data;
    logic        cfg_we     = 1'b0;
    logic [hpr_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [hpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the palette registers
    logic [1:0]  pal_mode  = hpr_pkg::MODE_PASS;
    logic [23:0] pal_one   = '0;
    logic [23:0] pal_two   = '0;
    logic [23:0] pal_three = '0;

    t_remap pending_pixels[$];
    int     error_count  = 0;
    int     cycle_count  = 0;
    bit     src_idle_on  = 1'b0;
    bit     sink_idle_on = 1'b0;
    bit     hold_req     = 1'b0;

    hue_palette_remap uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_data),   // in_red [7:0], in_green [15:8], in_blue [23:16]
        .o_m_axis_tvalid (sink_valid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (sink_data),  // out_red [7:0], out_green [15:8], out_blue [23:16]
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // global watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats pending",
                     cycle_count, pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // predictor
    //------------------------------------------------------------------

    // palette channel: 0 red (23:16), 1 green, 2 blue
    function automatic int unsigned tone(input logic [23:0] color, input int ch);
        return {24'd0, color[16 - 8 * ch +: 8]};
    endfunction

    function automatic int unsigned blend(input int unsigned a, input int unsigned b,
                                          input int unsigned t);
        return (a * (FULL_SCALE - t) + b * t) / FULL_SCALE;
    endfunction

    function automatic int unsigned pixel_hue(input int r, input int g, input int b);
        int hi;
        int lo;
        int span;
        int h;
        hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        span = hi - lo;
        if (span == 0)
            return 0;
        // ties on the max go to red, then green; division truncates toward zero
        if (hi == r)
            h = (HUE_SECTOR * (g - b)) / span;
        else if (hi == g)
            h = HUE_GREEN + (HUE_SECTOR * (b - r)) / span;
        else
            h = HUE_BLUE + (HUE_SECTOR * (r - g)) / span;
        if (h < 0)
            h += HUE_WRAP;
        return h & 8'hFF;
    endfunction

    function automatic t_pixel remap_pixel(input t_pixel px);
        int unsigned chan_in [3];
        int unsigned chan_out [3];
        int unsigned bright;
        int unsigned hue;
        int unsigned gain;
        int unsigned mapped;
        t_pixel      res;
        chan_in[0] = {24'd0, px.red};
        chan_in[1] = {24'd0, px.green};
        chan_in[2] = {24'd0, px.blue};
        bright = chan_in[0];
        if (chan_in[1] > bright) bright = chan_in[1];
        if (chan_in[2] > bright) bright = chan_in[2];
        if (pal_mode == hpr_pkg::MODE_PASS || bright == 0)
            return px;
        hue  = pixel_hue(chan_in[0], chan_in[1], chan_in[2]);
        gain = bright * GAIN_SCALE / FULL_SCALE;
        for (int ch = 0; ch < 3; ch++) begin
            mapped = 0;
            if (pal_mode == hpr_pkg::MODE_DUO) begin
                mapped = blend(tone(pal_one, ch), tone(pal_two, ch), hue);
            end else if (pal_mode == hpr_pkg::MODE_TRIO) begin
                if (hue < HUE_HALF)
                    mapped = blend(tone(pal_one, ch), tone(pal_two, ch), (hue * 2) & 8'hFF);
                else
                    mapped = blend(tone(pal_two, ch), tone(pal_three, ch),
                                   ((hue - HUE_HALF) * 2) & 8'hFF);
            end
            chan_out[ch] = (mapped * gain / GAIN_SCALE) & 8'hFF;
        end
        res.red   = 8'(chan_out[0]);
        res.green = 8'(chan_out[1]);
        res.blue  = 8'(chan_out[2]);
        return res;
    endfunction

    //------------------------------------------------------------------
    // checking
    //------------------------------------------------------------------

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk) begin : check_beat
        t_remap exp;
        t_pixel got;
        if (rst_n && sink_valid && sink_ready) begin
            got = sink_data;
            if (pending_pixels.size() == 0) begin
                report_error($sformatf("output beat %06h with nothing expected", got));
            end else begin
                exp = pending_pixels.pop_front();
                if (got.red !== exp.want.red)
                    report_error($sformatf("in %06h mode %0d: red %02h, expected %02h",
                                           exp.src, pal_mode, got.red, exp.want.red));
                if (got.green !== exp.want.green)
                    report_error($sformatf("in %06h mode %0d: green %02h, expected %02h",
                                           exp.src, pal_mode, got.green, exp.want.green));
                if (got.blue !== exp.want.blue)
                    report_error($sformatf("in %06h mode %0d: blue %02h, expected %02h",
                                           exp.src, pal_mode, got.blue, exp.want.blue));
            end
        end
    end

    //------------------------------------------------------------------
    // sink pacing: random stall bursts, and a long hold on request
    //------------------------------------------------------------------
    initial begin : sink_pacing
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                sink_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_ready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                sink_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                sink_ready <= 1'b1;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // stimulus helpers
    //------------------------------------------------------------------

    // one beat on the input; valid stays high for a back-to-back follower
    task automatic send_pixel(input t_pixel px);
        t_remap item;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            src_valid <= 1'b0;
            src_data  <= 24'($urandom());
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= px;
        @(posedge clk);
        while (!src_ready) @(posedge clk);
        item.src  = px;
        item.want = remap_pixel(px);
        pending_pixels.push_back(item);
    endtask

    // stop offering and wait until every expected beat is back
    task automatic drain_pipe();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            hpr_pkg::REG_MODE:  pal_mode  = val[1:0];
            hpr_pkg::REG_ONE:   pal_one   = val;
            hpr_pkg::REG_TWO:   pal_two   = val;
            hpr_pkg::REG_THREE: pal_three = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_palette(input logic [1:0] mode, input logic [23:0] one,
                               input logic [23:0] two, input logic [23:0] three);
        write_reg(hpr_pkg::REG_MODE, {22'd0, mode});
        write_reg(hpr_pkg::REG_ONE, one);
        write_reg(hpr_pkg::REG_TWO, two);
        write_reg(hpr_pkg::REG_THREE, three);
    endtask

    function automatic t_pixel mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // mix of plain random, tied maxima, saturated, gray and very dim pixels
    function automatic t_pixel rand_pixel();
        logic [7:0] hi;
        t_pixel     px;
        px = 24'($urandom());
        hi = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 9))
            4: px = mk_pixel(hi, hi, 8'($urandom_range(0, hi)));
            5: px = mk_pixel(hi, 8'($urandom_range(0, hi)), hi);
            6: px = mk_pixel(8'($urandom_range(0, hi)), hi, hi);
            7: px = mk_pixel(8'($urandom_range(0, 1) * 8'hFF),
                             8'($urandom_range(0, 1) * 8'hFF),
                             8'($urandom_range(0, 1) * 8'hFF));
            8: px = mk_pixel(hi, hi, hi);
            9: px = mk_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                             8'($urandom_range(0, 3)));
            default: ;
        endcase
        return px;
    endfunction

    function automatic logic [23:0] rand_color();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    //------------------------------------------------------------------
    // tests
    //------------------------------------------------------------------

    // registers at reset value: pixels pass through
    task automatic test_reset_passthrough();
        send_pixel(mk_pixel(8'h00, 8'h00, 8'h00));
        send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF));
        send_pixel(mk_pixel(8'h12, 8'hA5, 8'h3C));
        drain_pipe();
    endtask

    // two-color mode: hue sectors, ties on the max, negative hue, black
    task automatic test_duo_gradient();
        set_palette(hpr_pkg::MODE_DUO, 24'hFF0000, 24'h00FF00, 24'h000000);
        send_pixel(mk_pixel(8'h00, 8'h00, 8'h00));   // black
        send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF));   // gray, zero span
        send_pixel(mk_pixel(8'hFF, 8'h00, 8'h00));   // red sector, hue 0
        send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00));   // green sector
        send_pixel(mk_pixel(8'h00, 8'h00, 8'hFF));   // blue sector
        send_pixel(mk_pixel(8'hFF, 8'hFF, 8'h00));   // red/green tie
        send_pixel(mk_pixel(8'h00, 8'hFF, 8'hFF));   // green/blue tie
        send_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF));   // red/blue tie, negative hue
        send_pixel(mk_pixel(8'hC8, 8'h10, 8'h64));   // negative hue, truncation
        send_pixel(mk_pixel(8'h01, 8'h00, 8'h00));   // dimmest non-black
        drain_pipe();
    endtask

    // three-color mode on both halves of the hue range, colors at extremes
    task automatic test_trio_gradient();
        set_palette(hpr_pkg::MODE_TRIO, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00));   // hue 85, lower half
        send_pixel(mk_pixel(8'h00, 8'hFF, 8'hFD));   // just below half
        send_pixel(mk_pixel(8'h00, 8'hFC, 8'hFF));   // just above half
        send_pixel(mk_pixel(8'h00, 8'h00, 8'hFF));   // hue 171, upper half
        send_pixel(mk_pixel(8'hFF, 8'h00, 8'h01));   // hue 0, negative difference truncates to zero
        send_pixel(mk_pixel(8'h80, 8'h7F, 8'h40));
        drain_pipe();
    endtask

    // spare mode code gives black; then pass through written explicitly
    task automatic test_spare_mode();
        set_palette(MODE_SPARE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(mk_pixel(8'hFF, 8'h80, 8'h01));
        send_pixel(mk_pixel(8'h00, 8'h00, 8'h00));
        drain_pipe();
        write_reg(hpr_pkg::REG_MODE, {22'd0, hpr_pkg::MODE_PASS});
        send_pixel(mk_pixel(8'h5A, 8'hC3, 8'h0F));
        drain_pipe();
    endtask

    // long sink hold while the source keeps offering: pipeline fills and stalls
    task automatic test_backpressure();
        set_palette(hpr_pkg::MODE_TRIO, rand_color(), rand_color(), rand_color());
        src_idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (30) send_pixel(rand_pixel());
        drain_pipe();
    endtask

    // random palettes, random pixels, idling on both sides
    task automatic test_random_palettes();
        logic [1:0] mode;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0, 2, 4: mode = hpr_pkg::MODE_DUO;
                1, 3, 5: mode = hpr_pkg::MODE_TRIO;
                default: mode = 2'($urandom_range(0, 3));
            endcase
            set_palette(mode, rand_color(), rand_color(), rand_color());
            repeat (55) send_pixel(rand_pixel());
            drain_pipe();
        end
    endtask

    // closing stretch at full rate, no idling anywhere
    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_palette(hpr_pkg::MODE_TRIO, rand_color(), rand_color(), rand_color());
        repeat (60) send_pixel(rand_pixel());
        drain_pipe();
    endtask

    initial begin : run_tests
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_passthrough();
        test_duo_gradient();
        test_trio_gradient();
        test_spare_mode();
        test_backpressure();
        test_random_palettes();
        test_full_rate();
        // catch any stray beat after the last expected one
        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/hpr_pkg.sv
hw/rtl/hpr_front.sv
hw/rtl/hpr_hue_div.sv
hw/rtl/hpr_mix.sv
hw/rtl/hue_palette_remap.sv
verif/testbench.sv
